### rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check on the block clock, off during reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check on the block clock, off during reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ptts_pkg.sv
// package with command codes, field widths and slot entry type of the tick scheduler
package ptts_pkg;

	localparam int CMD_W     = 3;
	localparam int ID_W      = 4;
	localparam int DATA_W    = 16;
	localparam int MASK_W    = 16;
	localparam int NUM_TASKS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

	// one slot as kept in the slot memory
	typedef struct packed {
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] countdown;
	} slot_entry_t;

endpackage

### rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler. Create, suspend, resume and delete beats give no result. A tick
// beat walks the slot memory one slot per cycle through its single read port, with a
// read-modify-write pipeline behind it, and ends with the fired mask in the output register;
// no input beat is taken during the walk, nor until the fired mask has been loaded into that
// register, so a beat that follows a tick waits for the whole walk. The
// fired mask waits in its output register while command beats keep flowing; a following tick
// finishes its walk and then waits until that register is free. Ready and present flags sit in
// flip-flops cleared by reset, so period and countdown storage needs no clearing pass.
`include "assert_macros.svh"

module periodic_task_tick_scheduler #(
	parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ptts_pkg::CMD_W-1:0]  cmd,
	input  logic [ptts_pkg::ID_W-1:0]   task_id,
	input  logic [ptts_pkg::DATA_W-1:0] period,
	input  logic [ptts_pkg::DATA_W-1:0] first_delay,
	input  logic                        ready_init,
	input  logic                        has_handler,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ptts_pkg::MASK_W-1:0] fired_mask
);
	import ptts_pkg::*;

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int EXT_W = 7;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        rd_ptr_q;
	logic                    valid_s1;
	logic                    en_s1;
	logic [IDX_W-1:0]        idx_s1;
	slot_entry_t             rd_data_s1;
	logic [MASK_W-1:0]       mask_q;
	logic [NUM_TASKS-1:0]    ready_q;
	logic [NUM_TASKS-1:0]    present_q;
	logic                    out_valid_q;
	logic [MASK_W-1:0]       fired_mask_q;

	slot_entry_t             mem [NUM_TASKS];

	logic                    in_beat;
	logic                    out_free;
	logic                    out_load;
	logic                    tick_beat;
	logic                    walking;
	logic [EXT_W-1:0]        id_ext;
	logic                    id_ok;
	logic [IDX_W-1:0]        id_idx;
	logic                    create_wr;
	logic                    fired;
	logic [DATA_W-1:0]       new_cd;
	logic [MASK_W-1:0]       fire_bit;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	slot_entry_t             wr_data;

	// handshake decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign out_valid = out_valid_q;
	assign fired_mask = fired_mask_q;
	assign tick_beat = in_beat && (cmd == CMD_TICK);
	assign walking   = (state_q == ST_WALK) || (state_q == ST_FLUSH);

	// slot address check
	assign id_ext = EXT_W'(task_id);
	assign id_ok  = (id_ext < EXT_W'(NUM_TASKS));
	assign id_idx = id_ext[IDX_W-1:0];
	assign create_wr = in_beat && (cmd == CMD_CREATE) && id_ok;

	// countdown update for the slot coming out of memory
	always_comb begin
		fired  = (rd_data_s1.countdown == '0);
		new_cd = fired ? (rd_data_s1.period - DATA_W'(1)) : (rd_data_s1.countdown - DATA_W'(1));
		fire_bit = '0;
		for (int j = 0; j < MASK_W; j++) begin
			if (32'(idx_s1) == j) begin
				fire_bit[j] = 1'b1;
			end
		end
	end

	// memory write port, create in idle or write-back during the walk
	always_comb begin
		if (create_wr) begin
			wr_en             = 1'b1;
			wr_addr           = id_idx;
			wr_data.period    = period;
			wr_data.countdown = first_delay;
		end else begin
			wr_en             = valid_s1 && en_s1;
			wr_addr           = idx_s1;
			wr_data.period    = rd_data_s1.period;
			wr_data.countdown = new_cd;
		end
	end

	// slot memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_ptr_q];
	end

	// walk control, slot flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_ptr_q     <= '0;
			valid_s1     <= 1'b0;
			en_s1        <= 1'b0;
			idx_s1       <= '0;
			mask_q       <= '0;
			ready_q      <= '0;
			present_q    <= '0;
			out_valid_q  <= 1'b0;
			fired_mask_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				fired_mask_q <= mask_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			valid_s1 <= (state_q == ST_WALK);
			if (valid_s1 && en_s1 && fired) begin
				mask_q <= mask_q | fire_bit;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (cmd == CMD_TICK) begin
							state_q  <= ST_WALK;
							rd_ptr_q <= '0;
							mask_q   <= '0;
						end else if (id_ok) begin
							unique case (cmd)
								CMD_CREATE: begin
									ready_q[id_idx]   <= ready_init;
									present_q[id_idx] <= has_handler;
								end
								CMD_SUSPEND: ready_q[id_idx] <= 1'b0;
								CMD_RESUME:  ready_q[id_idx] <= 1'b1;
								CMD_DELETE: begin
									ready_q[id_idx]   <= 1'b0;
									present_q[id_idx] <= 1'b0;
								end
								default: ;
							endcase
						end
					end
				end
				ST_WALK: begin
					idx_s1   <= rd_ptr_q;
					en_s1    <= ready_q[rd_ptr_q] && present_q[rd_ptr_q];
					if (rd_ptr_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						rd_ptr_q <= rd_ptr_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`CHK_NEXT(a_tick_walks, clk, arst_n, tick_beat, state_q == ST_WALK, "tick did not start a walk")
	`CHK_IMPL(a_s1_in_walk, clk, arst_n, valid_s1, walking, "slot pipeline active outside a walk")
	`CHK_IMPL(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(out_load), "result not loaded")
	`CHK_IMPL(a_no_wr_clash, clk, arst_n, create_wr, !(valid_s1 && en_s1), "create meets write-back")

endmodule
